/* rtl/strz_pkg.sv */
// Package for the scanline triangle depth-buffer rasteriser: constants, types and helpers.
package strz_pkg;

  localparam int unsigned StoreWidth  = 256;
  localparam int unsigned StoreHeight = 256;
  localparam int unsigned DepthBits   = 24;
  localparam int unsigned StoreSize   = StoreWidth * StoreHeight;
  localparam int unsigned XBits       = $clog2(StoreWidth);
  localparam int unsigned YBits       = $clog2(StoreHeight);
  localparam int unsigned AddrBits    = XBits + YBits;
  localparam int unsigned ColorBits   = 24;
  localparam int unsigned CfgBits     = 13;
  localparam int unsigned PaddrBits   = 4;

  // Register byte addresses.
  localparam logic [PaddrBits-1:0] RegBandTop   = 4'h0;
  localparam logic [PaddrBits-1:0] RegBandBot   = 4'h4;
  localparam logic [PaddrBits-1:0] RegActWidth  = 4'h8;
  localparam logic [PaddrBits-1:0] RegActHeight = 4'hC;

  localparam logic OpDraw = 1'b0;
  localparam logic OpRead = 1'b1;

  // Divider operand widths: numerators hold a*den + d*num.
  localparam int unsigned DivNumBits = 48;
  localparam int unsigned DivDenBits = 16;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SORT1,
    ST_SORT2,
    ST_SETUP,
    ST_ROW,
    ST_EDGE_XA,
    ST_EDGE_ZA,
    ST_EDGE_XB,
    ST_EDGE_ZB,
    ST_SPAN,
    ST_PIX,
    ST_PIX_DIV,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_OUT
  } state_e;

  // Colour swizzle from 0x00BBGGRR to 0x00RRGGBB.
  function automatic logic [ColorBits-1:0] swizzle(input logic [ColorBits-1:0] c);
    swizzle = {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

/* rtl/strz_ram.sv */
// Generic single-port RAM with a registered read.
module strz_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One access per cycle; read data appears the cycle after.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/strz_div.sv */
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module strz_div
  import strz_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DivNumBits-1:0] num_i,
  input  logic        [DivDenBits-1:0] den_i,
  output logic                         done_o,
  output logic signed [DivNumBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(DivNumBits + 1);

  logic [DivNumBits-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [DivDenBits-1:0] den_q, den_d;
  logic                  neg_q, neg_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [DivNumBits:0]   trial;

  // Restoring division on magnitudes, sign fixed at the end.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      neg_d  = num_i[DivNumBits-1];
      quo_d  = num_i[DivNumBits-1] ? DivNumBits'(-num_i) : DivNumBits'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(DivNumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[DivNumBits-1]} - {{(DivNumBits+1-DivDenBits){1'b0}}, den_q};
      if (!trial[DivNumBits]) begin
        rem_d = trial[DivNumBits-1:0];
        quo_d = {quo_q[DivNumBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivNumBits-2:0], quo_q[DivNumBits-1]};
        quo_d = {quo_q[DivNumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1)) && !start_i;
  assign quot_o = neg_d ? -$signed(quo_d) : $signed(quo_d);

endmodule

/* rtl/scanline_triangle_zbuffer_raster_core.sv */
// Top level of the scanline triangle rasteriser with depth and colour stores.
// After reset the block clears both 65536-entry stores, one pixel a cycle,
// and takes no word until that pass is done; configuration writes are taken throughout.
// A read word passes through the wait, data and output states. A draw word is sorted and
// set up, then for every covered row divides x and depth per edge on the shared serial
// divider, and for every covered pixel a depth division when the row's span is not zero,
// plus a store read and, if nearer, a write. The single store port and the bit-serial
// divider set the pace of a draw. Exactly one result word follows every input word.
module scanline_triangle_zbuffer_raster_core
  import strz_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic signed [13:0]   v0_x_i,
  input  logic signed [13:0]   v0_y_i,
  input  logic [23:0]          v0_z_i,
  input  logic signed [13:0]   v1_x_i,
  input  logic signed [13:0]   v1_y_i,
  input  logic [23:0]          v1_z_i,
  input  logic signed [13:0]   v2_x_i,
  input  logic signed [13:0]   v2_y_i,
  input  logic [23:0]          v2_z_i,
  input  logic [23:0]          tri_color_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          pixel_color_o,
  output logic [23:0]          pixel_depth_o,
  output logic                 read_valid_o
);

  typedef logic signed [15:0] crd_t;
  typedef logic signed [25:0] dep_t;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgBits-1:0] band_top_q, band_bot_q, act_w_q, act_h_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_top_q <= '0;
      band_bot_q <= CfgBits'(256);
      act_w_q    <= CfgBits'(256);
      act_h_q    <= CfgBits'(256);
    end else if (cfg_wr) begin
      case (paddr)
        RegBandTop:   band_top_q <= pwdata[CfgBits-1:0];
        RegBandBot:   band_bot_q <= pwdata[CfgBits-1:0];
        RegActWidth:  act_w_q    <= pwdata[CfgBits-1:0];
        RegActHeight: act_h_q    <= pwdata[CfgBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegBandTop:   prdata = {{(32-CfgBits){1'b0}}, band_top_q};
      RegBandBot:   prdata = {{(32-CfgBits){1'b0}}, band_bot_q};
      RegActWidth:  prdata = {{(32-CfgBits){1'b0}}, act_w_q};
      RegActHeight: prdata = {{(32-CfgBits){1'b0}}, act_h_q};
      default:      prdata = '0;
    endcase
  end

  // Working registers for one word.
  crd_t               x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  dep_t               z0_q, z1_q, z2_q;
  logic [ColorBits-1:0] color_q;
  crd_t               y_q, yhi_q;
  crd_t               xa_q, xb_q, x_q, xhi_q;
  dep_t               za_q, zb_q, zp_q;
  logic [AddrBits-1:0] clr_q;
  logic [23:0]        oc_q, od_q;
  logic               orv_q;

  // Shared divider.
  logic                         div_start;
  logic signed [DivNumBits-1:0] div_num;
  logic        [DivDenBits-1:0] div_den;
  logic                         div_done;
  logic signed [DivNumBits-1:0] div_quot;

  strz_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Store port.
  logic                 mem_we;
  logic [AddrBits-1:0]  mem_addr;
  logic [DepthBits-1:0] dep_wdata, dep_rdata;
  logic [ColorBits-1:0] col_wdata, col_rdata;

  strz_ram #(.Width(DepthBits), .Depth(StoreSize)) u_depth (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(dep_wdata),
    .rdata_o(dep_rdata)
  );

  strz_ram #(.Width(ColorBits), .Depth(StoreSize)) u_color (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(col_wdata),
    .rdata_o(col_rdata)
  );

  // Edge selection for the current row.
  logic short_hi;
  crd_t eb_x, eb_y;
  dep_t eb_z;
  crd_t eb_dx, eb_dy;
  dep_t eb_dz;
  crd_t ea_num, eb_num;
  crd_t wclip, hclip;
  crd_t band_top_s, band_bot_s;

  assign band_top_s = crd_t'({3'b0, band_top_q});
  assign band_bot_s = crd_t'({3'b0, band_bot_q});
  assign wclip = (act_w_q < CfgBits'(StoreWidth)) ? crd_t'({3'b0, act_w_q})
                                                 : crd_t'(StoreWidth);
  assign hclip = (act_h_q < CfgBits'(StoreHeight)) ? crd_t'({3'b0, act_h_q})
                                                  : crd_t'(StoreHeight);

  always_comb begin
    short_hi = (y_q > y1_q) || (y1_q == y0_q);
    if (short_hi) begin
      eb_x = x1_q; eb_y = y1_q; eb_z = z1_q;
      eb_dx = x2_q - x1_q; eb_dz = z2_q - z1_q; eb_dy = y2_q - y1_q + crd_t'(1);
    end else begin
      eb_x = x0_q; eb_y = y0_q; eb_z = z0_q;
      eb_dx = x1_q - x0_q; eb_dz = z1_q - z0_q; eb_dy = y1_q - y0_q + crd_t'(1);
    end
    ea_num = y_q - y0_q;
    eb_num = y_q - eb_y;
  end

  // Divider operands per state: a*den + d*num over den.
  crd_t ea_den;
  crd_t span;
  assign ea_den = y2_q - y0_q + crd_t'(1);
  assign span   = xb_q - xa_q;

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_q)
      ST_EDGE_XA: begin
        div_num = DivNumBits'(48'(x0_q) * 48'(ea_den) + 48'(x2_q - x0_q) * 48'(ea_num));
        div_den = DivDenBits'(ea_den);
      end
      ST_EDGE_ZA: begin
        div_num = DivNumBits'(48'(z0_q) * 48'(ea_den) + 48'(z2_q - z0_q) * 48'(ea_num));
        div_den = DivDenBits'(ea_den);
      end
      ST_EDGE_XB: begin
        div_num = DivNumBits'(48'(eb_x) * 48'(eb_dy) + 48'(eb_dx) * 48'(eb_num));
        div_den = DivDenBits'(eb_dy);
      end
      ST_EDGE_ZB: begin
        div_num = DivNumBits'(48'(eb_z) * 48'(eb_dy) + 48'(eb_dz) * 48'(eb_num));
        div_den = DivDenBits'(eb_dy);
      end
      ST_PIX: begin
        div_num = DivNumBits'(48'(za_q) * 48'(span) + 48'(x_q - xa_q) * 48'(zb_q - za_q));
        div_den = DivDenBits'(span);
      end
      default: ;
    endcase
  end

  logic div_busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_busy_q <= 1'b0;
    else if (div_done) div_busy_q <= 1'b0;
    else if (div_start) div_busy_q <= 1'b1;
  end

  // Start the divider once on entry to each dividing state.
  always_comb begin
    div_start = 1'b0;
    case (state_q)
      ST_EDGE_XA, ST_EDGE_ZA, ST_EDGE_XB, ST_EDGE_ZB: div_start = !div_busy_q;
      ST_PIX: div_start = (x_q <= xhi_q) && (span != crd_t'(0));
      default: ;
    endcase
  end

  logic        read_in;
  logic [AddrBits-1:0] pix_addr, rd_addr;
  assign read_in  = (v0_x_i >= 0) && (v0_x_i < 14'(StoreWidth)) &&
                    (v0_y_i >= 0) && (v0_y_i < 14'(StoreHeight));
  assign pix_addr = {y_q[YBits-1:0], x_q[XBits-1:0]};
  assign rd_addr  = {v0_y_i[YBits-1:0], v0_x_i[XBits-1:0]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) state_d = (op_i == OpRead) ? ST_RD_WAIT : ST_SORT1;
      ST_RD_WAIT: state_d = ST_RD_DATA;
      ST_RD_DATA: state_d = ST_OUT;
      ST_SORT1:   state_d = ST_SORT2;
      ST_SORT2:   state_d = ST_SETUP;
      ST_SETUP:   state_d = (y0_q >= band_bot_s || y2_q < band_top_s) ? ST_OUT : ST_ROW;
      ST_ROW:     state_d = (y_q > yhi_q) ? ST_OUT : ST_EDGE_XA;
      ST_EDGE_XA: if (div_done) state_d = ST_EDGE_ZA;
      ST_EDGE_ZA: if (div_done) state_d = ST_EDGE_XB;
      ST_EDGE_XB: if (div_done) state_d = ST_EDGE_ZB;
      ST_EDGE_ZB: if (div_done) state_d = ST_SPAN;
      ST_SPAN:    state_d = ST_PIX;
      ST_PIX: begin
        if (x_q > xhi_q) state_d = ST_ROW;
        else if (span != crd_t'(0)) state_d = ST_PIX_DIV;
        else state_d = ST_PIX_RD;
      end
      ST_PIX_DIV: if (div_done) state_d = ST_PIX_RD;
      ST_PIX_RD:  state_d = ST_PIX_WR;
      ST_PIX_WR:  state_d = ST_PIX;
      ST_OUT:     if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Store port and handshake outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pix_addr;
    dep_wdata = zp_q[DepthBits-1:0];
    col_wdata = color_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        dep_wdata = '1;
        col_wdata = '0;
      end
      ST_IDLE: mem_addr = rd_addr;
      ST_PIX_WR: mem_we = (zp_q[DepthBits-1:0] < dep_rdata);
      default: ;
    endcase
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign pixel_color_o = oc_q;
  assign pixel_depth_o = od_q;
  assign read_valid_o  = orv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x0_q <= crd_t'(v0_x_i); y0_q <= crd_t'(v0_y_i); z0_q <= dep_t'(v0_z_i);
        x1_q <= crd_t'(v1_x_i); y1_q <= crd_t'(v1_y_i); z1_q <= dep_t'(v1_z_i);
        x2_q <= crd_t'(v2_x_i); y2_q <= crd_t'(v2_y_i); z2_q <= dep_t'(v2_z_i);
        color_q <= swizzle(tri_color_i);
        oc_q  <= '0;
        od_q  <= '0;
        orv_q <= (op_i == OpRead) && read_in;
      end
      ST_RD_WAIT: begin
        // The store was read at the accepting edge; its data is valid now.
        if (orv_q) begin
          oc_q <= col_rdata;
          od_q <= dep_rdata;
        end
      end
      ST_SORT1: begin
        // Compare-and-swap (0,1) then (0,2) on the result.
        if (y0_q > y1_q) begin
          if (y1_q > y2_q) begin
            x0_q <= x2_q; y0_q <= y2_q; z0_q <= z2_q;
            x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
          end else begin
            x0_q <= x1_q; y0_q <= y1_q; z0_q <= z1_q;
          end
          x1_q <= x0_q; y1_q <= y0_q; z1_q <= z0_q;
        end else if (y0_q > y2_q) begin
          x0_q <= x2_q; y0_q <= y2_q; z0_q <= z2_q;
          x2_q <= x0_q; y2_q <= y0_q; z2_q <= z0_q;
        end
      end
      ST_SORT2: begin
        if (y1_q > y2_q) begin
          x1_q <= x2_q; y1_q <= y2_q; z1_q <= z2_q;
          x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
        end
      end
      ST_SETUP: begin
        y_q <= (y0_q < band_top_s) ? band_top_s : ((y0_q < 0) ? crd_t'(0) : y0_q);
        if (y2_q > band_bot_s - crd_t'(1)) begin
          yhi_q <= (band_bot_s - crd_t'(1) > hclip - crd_t'(1)) ? hclip - crd_t'(1)
                                                                : band_bot_s - crd_t'(1);
        end else begin
          yhi_q <= (y2_q > hclip - crd_t'(1)) ? hclip - crd_t'(1) : y2_q;
        end
      end
      ST_EDGE_XA: if (div_done) xa_q <= crd_t'(div_quot);
      ST_EDGE_ZA: if (div_done) za_q <= dep_t'(div_quot);
      ST_EDGE_XB: if (div_done) xb_q <= crd_t'(div_quot);
      ST_EDGE_ZB: if (div_done) zb_q <= dep_t'(div_quot);
      ST_SPAN: begin
        // Order the span ends and clip it to the screen.
        if (xa_q > xb_q) begin
          xa_q <= xb_q; xb_q <= xa_q; za_q <= zb_q; zb_q <= za_q;
          x_q   <= (xb_q > 0) ? xb_q : crd_t'(0);
          xhi_q <= (xa_q < wclip - crd_t'(1)) ? xa_q : wclip - crd_t'(1);
        end else begin
          x_q   <= (xa_q > 0) ? xa_q : crd_t'(0);
          xhi_q <= (xb_q < wclip - crd_t'(1)) ? xb_q : wclip - crd_t'(1);
        end
      end
      ST_PIX: begin
        zp_q <= za_q;
        if (x_q > xhi_q) y_q <= y_q + crd_t'(1);
      end
      ST_PIX_DIV: if (div_done) zp_q <= dep_t'(div_quot);
      ST_PIX_WR: x_q <= x_q + crd_t'(1);
      default: ;
    endcase
  end

endmodule
